[rtl/ptu_pkg.sv]
// Package for the pheromone table update core: constants, types, helpers.
// No dependencies.
package ptu_pkg;

    localparam int MaxStations = 64;
    localparam int NodeW       = $clog2(MaxStations);
    localparam int AddrW       = 2 * NodeW;
    localparam int Depth       = MaxStations * MaxStations;
    localparam int LevelW      = 32;
    localparam int LenW        = 16;
    localparam int CfgIdxW     = 3;
    localparam int CountW      = 7;

    // Queue depth must be a power of two so the pointers wrap on their own
    localparam int QueueDepth  = 2;
    localparam int QPtrW       = $clog2(QueueDepth);
    localparam int QCntW       = $clog2(QueueDepth + 1);

    // Dividend 100*opt*65536 fits in 39 bits.
    localparam int DivW        = 39;

    // Divide by 100 of a 39-bit product: p = hi*2^20 + lo, 2^20 = 10485*100 + 76,
    // then the small remainder term goes through ceil(2^33/100)
    localparam int               Quot20By100 = 10485;
    localparam int               Rem20By100  = 76;
    localparam logic [26:0]      Recip100    = 27'd85899346;

    localparam logic [LevelW-1:0] LowerReset = 32'd131072;
    localparam logic [LevelW-1:0] UpperReset = 32'd32768000;

    // Register indexes
    localparam logic [CfgIdxW-1:0] RegOptimal = 3'd0;
    localparam logic [CfgIdxW-1:0] RegUpper   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegLower   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegPercent = 3'd3;
    localparam logic [CfgIdxW-1:0] RegCount   = 3'd4;

    // Bound hit codes
    localparam logic [1:0] HitNone  = 2'd0;
    localparam logic [1:0] HitLower = 2'd1;
    localparam logic [1:0] HitUpper = 2'd2;

    // Queued command from front to back
    typedef struct packed {
        logic             evap;
        logic             skip;
        logic [NodeW-1:0] node_a;
        logic [NodeW-1:0] node_b;
        logic [LenW-1:0]  way_length;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_DRD,
        ST_DWAIT,
        ST_DWR_A,
        ST_DWR_B,
        ST_ERD,
        ST_EWAIT,
        ST_EMUL,
        ST_EDIV,
        ST_EWR_A,
        ST_EWR_B,
        ST_OUT
    } state_t;

endpackage

[rtl/ptu_if.sv]
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface ptu_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/ptu_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
module ptu_ram #(
    parameter int Width = 32,
    parameter int Depth = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/ptu_front.sv]
// Front part: accepts input words, classifies them, queues commands.
// Depends on ptu_pkg and ptu_if.
module ptu_front
    import ptu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ptu_if.sink   in_ch,
    input  logic  q_pop,
    output logic  q_valid,
    output cmd_t  q_cmd,
    output logic  busy
);
    cmd_t             q_reg [QueueDepth];
    logic [QCntW-1:0] cnt_reg, cnt_next;
    logic [QPtrW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic             push;
    cmd_t             cmd_in;

    // Classify: evaporate, or a deposit possibly out of table
    always_comb
    begin
        cmd_in.evap       = in_ch.payload.mode;
        cmd_in.skip       = ((NodeW+1)'(in_ch.payload.node_a) >= (NodeW+1)'(MaxStations)) ||
                            ((NodeW+1)'(in_ch.payload.node_b) >= (NodeW+1)'(MaxStations));
        cmd_in.node_a     = in_ch.payload.node_a;
        cmd_in.node_b     = in_ch.payload.node_b;
        cmd_in.way_length = in_ch.payload.way_length;
    end

    assign in_ch.ready = (cnt_reg != QCntW'(QueueDepth));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign q_cmd       = q_reg[rd_reg];
    assign busy        = q_valid;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = q_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCntW'(push) - QCntW'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg  <= '0;
            rd_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cmd_in;
        end
    end
endmodule

[rtl/ptu_back.sv]
// Back part: clearing pass, deposit with iterative divider, evaporation sweep.
// Depends on ptu_pkg, ptu_if and ptu_ram.
module ptu_back
    import ptu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    input  logic [LenW-1:0]     optimal_length,
    input  logic [LevelW-1:0]   upper_bound,
    input  logic [LevelW-1:0]   lower_bound,
    input  logic [CountW-1:0]   evaporation_percent,
    input  logic [CountW-1:0]   station_count,
    ptu_if.source               out_ch,
    output state_t              state
);
    typedef struct packed {
        logic [LevelW-1:0] level;
        logic [1:0]        bound_hit;
    } res_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    logic [AddrW:0]     clr_reg;
    logic [DivW-1:0]    quo_reg, rem_reg;
    logic [LenW:0]      div_reg;
    logic [5:0]         step_reg;
    logic [NodeW-1:0]   row_reg, col_reg;
    logic [NodeW:0]     rows_reg;
    logic [6:0]         keep_reg;
    logic [38:0]        prod_reg;
    logic [25:0]        t_reg;
    logic [LevelW:0]    hiq_reg;
    logic [LevelW-1:0]  val_reg;
    logic [1:0]         hit_reg;
    res_t               res_reg;
    logic               ovalid_reg;

    logic               we;
    logic [AddrW-1:0]   addr;
    logic [LevelW-1:0]  wdata, rdata;

    ptu_ram #(.Width(LevelW), .Depth(Depth)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign state           = state_reg;
    assign out_ch.valid    = ovalid_reg;
    assign out_ch.payload  = res_reg;

    // Deposit sum with saturation and clamping
    logic [LevelW:0]   sum_w;
    logic [LevelW-1:0] sat_w, dep_val;
    logic [1:0]        dep_hit;
    always_comb
    begin
        sum_w = {1'b0, rdata} + ((quo_reg[DivW-1:LevelW] != '0) ?
                {1'b0, {LevelW{1'b1}}} : {1'b0, quo_reg[LevelW-1:0]});
        sat_w   = sum_w[LevelW] ? {LevelW{1'b1}} : sum_w[LevelW-1:0];
        dep_val = sat_w;
        dep_hit = HitNone;
        if (sat_w < lower_bound)
        begin
            dep_val = lower_bound;
            dep_hit = HitLower;
        end
        if (dep_val > upper_bound)
        begin
            dep_val = upper_bound;
            dep_hit = HitUpper;
        end
    end

    // Evaporation: high part quotient from the split, low part by reciprocal
    logic [52:0]       tq_w;
    logic [LevelW:0]   evq_w;
    logic [LevelW-1:0] ev_val;
    always_comb
    begin
        tq_w   = 53'(t_reg) * 53'(Recip100);
        evq_w  = hiq_reg + (LevelW+1)'(tq_w[52:33]);
        ev_val = (evq_w[LevelW-1:0] < lower_bound) ? lower_bound : evq_w[LevelW-1:0];
    end

    // Restoring division step
    logic [DivW:0] trial_w;
    always_comb
    begin
        trial_w = {rem_reg, quo_reg[DivW-1]} - {{(DivW-LenW){1'b0}}, div_reg};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == (AddrW+1)'(Depth - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid && !ovalid_reg)
                begin
                    if (q_cmd.evap)
                        state_next = (station_count == '0) ? ST_OUT : ST_ERD;
                    else
                        state_next = ST_DIV;
                end
            ST_DIV:   if (step_reg == 6'(DivW - 1)) state_next = ST_DRD;
            ST_DRD:   state_next = ST_DWAIT;
            ST_DWAIT: state_next = ST_DWR_A;
            ST_DWR_A: state_next = ST_DWR_B;
            ST_DWR_B: state_next = ST_OUT;
            ST_ERD:
                if (col_reg >= row_reg[NodeW-1:0] || row_reg == '0)
                    state_next = ((NodeW+1)'(row_reg) + 1'b1 >= rows_reg) ? ST_OUT : ST_ERD;
                else
                    state_next = ST_EWAIT;
            ST_EWAIT: state_next = ST_EMUL;
            ST_EMUL:  state_next = ST_EDIV;
            ST_EDIV:  state_next = ST_EWR_A;
            ST_EWR_A: state_next = ST_EWR_B;
            ST_EWR_B: state_next = ST_ERD;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Memory port and queue pop
    always_comb
    begin
        we    = 1'b0;
        addr  = {cmd_reg.node_a, cmd_reg.node_b};
        wdata = val_reg;
        q_pop = (state_reg == ST_OUT);
        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                addr  = clr_reg[AddrW-1:0];
                wdata = LowerReset;
            end
            ST_DRD, ST_DWAIT: addr = {cmd_reg.node_a, cmd_reg.node_b};
            ST_DWR_A:
            begin
                we    = !cmd_reg.skip;
                addr  = {cmd_reg.node_a, cmd_reg.node_b};
                wdata = dep_val;
            end
            ST_DWR_B:
            begin
                we    = !cmd_reg.skip;
                addr  = {cmd_reg.node_b, cmd_reg.node_a};
            end
            ST_ERD, ST_EWAIT, ST_EMUL, ST_EDIV, ST_EWR_A:
            begin
                addr  = {row_reg, col_reg};
                we    = (state_reg == ST_EWR_A);
                wdata = ev_val;
            end
            ST_EWR_B:
            begin
                we    = 1'b1;
                addr  = {col_reg, row_reg};
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_OUT)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg  <= q_cmd;
                step_reg <= '0;
                rem_reg  <= '0;
                quo_reg  <= DivW'({optimal_length, 16'd0}) * DivW'(100);
                div_reg  <= (q_cmd.way_length >= optimal_length) ?
                            (LenW+1)'(q_cmd.way_length) + 1'b1 - (LenW+1)'(optimal_length) :
                            (LenW+1)'(1);
                row_reg  <= '0;
                col_reg  <= '0;
                rows_reg <= (station_count > 7'(MaxStations)) ? (NodeW+1)'(MaxStations) :
                            station_count[NodeW:0];
                keep_reg <= (evaporation_percent > 7'd100) ? 7'd0 : 7'd100 - evaporation_percent;
                val_reg  <= '0;
                hit_reg  <= HitNone;
            end
            ST_DIV:
            begin
                step_reg <= step_reg + 1'b1;
                if (!trial_w[DivW])
                begin
                    rem_reg <= trial_w[DivW-1:0];
                    quo_reg <= {quo_reg[DivW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DivW-2:0], quo_reg[DivW-1]};
                    quo_reg <= {quo_reg[DivW-2:0], 1'b0};
                end
            end
            ST_DWR_A:
            begin
                val_reg <= dep_val;
                hit_reg <= dep_hit;
            end
            ST_ERD:
                if (col_reg >= row_reg || row_reg == '0)
                begin
                    row_reg <= row_reg + 1'b1;
                    col_reg <= '0;
                end
            ST_EMUL:  prod_reg <= 39'(rdata) * 39'(keep_reg);
            // Split the product at bit 20 for the divide by 100
            ST_EDIV:
            begin
                hiq_reg <= (LevelW+1)'(prod_reg[38:20]) * (LevelW+1)'(Quot20By100);
                t_reg   <= 26'(prod_reg[38:20]) * 26'(Rem20By100) + 26'(prod_reg[19:0]);
            end
            ST_EWR_A: val_reg <= ev_val;
            ST_EWR_B: col_reg <= col_reg + 1'b1;
            ST_OUT:
            begin
                res_reg.level     <= (cmd_reg.evap || cmd_reg.skip) ? '0 : val_reg;
                res_reg.bound_hit <= (cmd_reg.evap || cmd_reg.skip) ? HitNone : hit_reg;
            end
            default: ;
        endcase
    end
endmodule

[rtl/pheromone_table_update_core.sv]
// Top level of the pheromone table update core: config registers, front, back.
// Depends on ptu_pkg, ptu_if, ptu_front, ptu_back.
//
// channel  dir  handshake     payload
// in_ch    in   valid/ready   mode, node_a, node_b, way_length
// out_ch   out  valid/ready   level, bound_hit
// cfg      in   cfg_we        cfg_index, cfg_data
//
// A deposit runs through the 39-step restoring divider. An evaporation takes each
// lower-triangle entry through ST_ERD, ST_EWAIT, ST_EMUL, ST_EDIV, ST_EWR_A, ST_EWR_B.
// After reset a clearing pass writes the reset lower bound to all 4096 entries;
// no word is taken from the queue until it ends. Results wait in an output register;
// the two-entry queue keeps taking words while the back part works, until it is full.
module pheromone_table_update_core
    import ptu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ptu_if.sink                  in_ch,
    ptu_if.source                out_ch,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [LevelW-1:0]    cfg_data
);
    logic [LenW-1:0]   optimal_length_reg;
    logic [LevelW-1:0] upper_bound_reg, lower_bound_reg;
    logic [CountW-1:0] evaporation_percent_reg, station_count_reg;
    logic              q_pop, q_valid, busy;
    cmd_t              q_cmd;
    state_t            state;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            optimal_length_reg      <= '0;
            upper_bound_reg         <= UpperReset;
            lower_bound_reg         <= LowerReset;
            evaporation_percent_reg <= 7'd1;
            station_count_reg       <= 7'(MaxStations);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegOptimal: optimal_length_reg      <= cfg_data[LenW-1:0];
                RegUpper:   upper_bound_reg         <= cfg_data;
                RegLower:   lower_bound_reg         <= cfg_data;
                RegPercent: evaporation_percent_reg <= cfg_data[CountW-1:0];
                RegCount:   station_count_reg       <= cfg_data[CountW-1:0];
                default: ;
            endcase
        end
    end

    ptu_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_pop(q_pop), .q_valid(q_valid), .q_cmd(q_cmd), .busy(busy)
    );

    ptu_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .optimal_length(optimal_length_reg), .upper_bound(upper_bound_reg),
        .lower_bound(lower_bound_reg), .evaporation_percent(evaporation_percent_reg),
        .station_count(station_count_reg), .out_ch(out_ch), .state(state)
    );

    // Pops only happen with a queued word
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> busy)
        else $error("pop from empty queue");
    // A result stays valid until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
    // No work during the clearing pass
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_CLEAR) |-> !q_pop)
        else $error("pop during clear");
endmodule
